FILE: design/srv_pkg.sv
// Shared types, constants and arithmetic helpers of the spring reverb.
`timescale 1ns / 1ps

package srv_pkg;

	typedef logic signed [15:0] sample_t;
	typedef logic signed [19:0] st_t;
	typedef logic signed [21:0] opnd_t;
	typedef logic signed [29:0] wide_t;
	typedef logic signed [43:0] prod_t;
	typedef logic [15:0]        coef_t;
	typedef logic [3:0]         step_t;
	typedef logic [1:0]         line_t;
	typedef logic [1:0]         cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_PREP = 4'b0010,
		ST_LINE = 4'b0100,
		ST_MIX  = 4'b1000
	} state_t;

	localparam int    LINE_COUNT = 3;
	localparam line_t LAST_LINE  = 2'(LINE_COUNT - 1);
	localparam line_t LINE_A     = 2'd0;
	localparam line_t LINE_B     = 2'd1;
	localparam line_t LINE_C     = 2'd2;

	// register indexes of the configuration port
	localparam cfg_idx_t CFG_DECAY = 2'd0;
	localparam cfg_idx_t CFG_TONE  = 2'd1;
	localparam cfg_idx_t CFG_MIX   = 2'd2;

	// set-up steps
	localparam step_t PS_DECAY = 4'd0;
	localparam step_t PS_TONE  = 4'd1;
	localparam step_t PS_LPC   = 4'd2;

	// per-line steps
	localparam step_t LS_AP0_MUL_X = 4'd0;
	localparam step_t LS_AP0_OUT   = 4'd1;
	localparam step_t LS_AP0_MUL_Y = 4'd2;
	localparam step_t LS_AP0_ST    = 4'd3;
	localparam step_t LS_AP1_OUT   = 4'd4;
	localparam step_t LS_AP1_MUL_Y = 4'd5;
	localparam step_t LS_AP1_ST    = 4'd6;
	localparam step_t LS_LP_POST   = 4'd7;
	localparam step_t LS_FB_MUL    = 4'd8;
	localparam step_t LS_WRITE     = 4'd9;

	// output mixing steps
	localparam step_t MS_DIV = 4'd0;
	localparam step_t MS_WET = 4'd1;
	localparam step_t MS_DRY = 4'd2;
	localparam step_t MS_OUT = 4'd3;

	localparam opnd_t AP_C0      = -22'sd39322;
	localparam opnd_t AP_C1      = -22'sd26214;
	localparam opnd_t Q16_085    = 22'sd55706;
	localparam opnd_t Q16_060    = 22'sd39322;
	localparam coef_t LPC_BASE   = 16'd13107;
	// floor(n / 3) == (n * DIV3_RECIP) >> 22 for every n below 2^21
	localparam opnd_t DIV3_RECIP = 22'sd1398102;
	localparam logic [16:0] UNITY_Q16 = 17'h10000;

	localparam logic [9:0] TAP_A = 10'd347;
	localparam logic [9:0] TAP_B = 10'd419;
	localparam logic [9:0] TAP_C = 10'd571;

	function automatic logic [9:0] tap_len(input line_t l);
		logic [9:0] t;
		unique case (l)
			LINE_A:  t = TAP_A;
			LINE_B:  t = TAP_B;
			LINE_C:  t = TAP_C;
			default: t = TAP_A;
		endcase
		return t;
	endfunction

	// divide by 2^16, round to nearest, ties away from zero
	function automatic logic signed [27:0] rnd16(input prod_t v);
		prod_t t;
		t = v + 44'sd32767 + $signed({43'd0, ~v[43]});
		return t[43:16];
	endfunction

	function automatic st_t sat20(input wide_t v);
		st_t r;
		if (v > 30'sd524287)
			r = 20'sd524287;
		else if (v < -30'sd524288)
			r = -20'sd524288;
		else
			r = v[19:0];
		return r;
	endfunction

	function automatic sample_t sat16(input wide_t v);
		sample_t r;
		if (v > 30'sd32767)
			r = 16'sd32767;
		else if (v < -30'sd32768)
			r = -16'sd32768;
		else
			r = v[15:0];
		return r;
	endfunction

endpackage

FILE: design/three_line_spring_reverb.sv
// Top level of the three-line spring reverb: sequencer, shared multiplier and state.
`timescale 1ns / 1ps

// Spring-style reverb: three feedback delay lines (taps 347, 419 and 571 samples
// back), each with two allpass diffusers and a damping lowpass.
// Input channel: in_valid / in_stall with dry_sample. Output channel: out_valid /
// out_stall with mixed_sample. One output item for each input item, in order.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Write the registers only while the block is idle.
// Sequence: an item is taken in the idle state, then the set-up steps, the steps of
// each of the three lines and the mixing steps follow, and the result is loaded
// into the output register; a new item is taken only once the block is idle again.
// The pace is set by the single shared 22x22 multiplier and its registered
// product: every product is registered, then rounded and saturated, before a
// dependent product may start.
// Receiver stall: the finished result waits in the output register while the next
// item is already taken and processed; only the final mixing step holds until the
// output register is free.
// Reset: all line, allpass and lowpass state reads as zero and registers return to
// 32768. The delay memory is not cleared: an entry not yet written since reset
// (tracked by the write position and a wrap flag) reads as zero.
module three_line_spring_reverb #(
	parameter int LINE_DEPTH = 1024
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  srv_pkg::sample_t        dry_sample,
	output logic                    out_valid,
	input  logic                    out_stall,
	output srv_pkg::sample_t        mixed_sample,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  srv_pkg::cfg_idx_t       cfg_index,
	input  logic [15:0]             cfg_data
);
	import srv_pkg::*;

	localparam int PW        = $clog2(LINE_DEPTH);
	localparam int MEM_DEPTH = LINE_COUNT * LINE_DEPTH;
	localparam int MAW       = $clog2(MEM_DEPTH);
	localparam logic [PW:0]    DEPTH_EXT = (PW + 1)'(LINE_DEPTH);
	localparam logic [PW-1:0]  POS_LAST  = PW'(LINE_DEPTH - 1);
	localparam logic [MAW-1:0] BASE_B    = MAW'(LINE_DEPTH);
	localparam logic [MAW-1:0] BASE_C    = MAW'(2 * LINE_DEPTH);

	// control state
	state_t        state_q;
	step_t         step_q;
	line_t         line_q;
	logic [PW-1:0] wp_q;
	logic          wrapped_q;
	coef_t         decay_amt_q;
	coef_t         tone_amt_q;
	coef_t         mix_amt_q;
	st_t           ap0_q [LINE_COUNT];
	st_t           ap1_q [LINE_COUNT];
	st_t           lp_q  [LINE_COUNT];
	logic          out_valid_q;

	// working registers
	sample_t       dry_q;
	sample_t       mixed_q;
	prod_t         prod_q;
	prod_t         acc_q;
	coef_t         decay_q;
	coef_t         lpc_q;
	st_t           xa_q;
	st_t           y_q;
	logic signed [20:0] diff_q;
	logic signed [21:0] wet_q;
	logic [21:0]   n_q;
	logic          wet_neg_q;
	logic signed [20:0] wet_mean_q;
	logic          rd_ok_q;

	// combinational
	logic          in_acc;
	logic          cfg_we;
	logic          out_free;
	logic          out_load;
	logic          is_prep;
	logic          is_line;
	logic          is_mix;
	logic          mul_en;
	opnd_t         op_a;
	opnd_t         op_b;
	sample_t       rd_data;
	sample_t       x_in;
	logic          rd_en;
	line_t         rd_line;
	logic [9:0]    rd_tap;
	logic [PW:0]   rp_full;
	logic [PW-1:0] rp;
	logic          rd_valid_entry;
	logic [MAW-1:0] rd_addr;
	logic          wr_en;
	logic [MAW-1:0] wr_addr;
	sample_t       wr_data;
	logic signed [27:0] p_rnd;
	wide_t         p_rnd_w;
	st_t           ap_cur;
	st_t           y_new;
	st_t           apw_new;
	st_t           lp_new;
	prod_t         mix_sum;
	sample_t       out_new;
	logic signed [21:0] wet_abs;
	logic [16:0]   dry_weight;
	logic [19:0]   wet_mag;

	function automatic logic [MAW-1:0] line_base(input line_t l);
		logic [MAW-1:0] b;
		unique case (l)
			LINE_A:  b = '0;
			LINE_B:  b = BASE_B;
			LINE_C:  b = BASE_C;
			default: b = '0;
		endcase
		return b;
	endfunction

	assign is_prep  = (state_q == ST_PREP);
	assign is_line  = (state_q == ST_LINE);
	assign is_mix   = (state_q == ST_MIX);

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	assign out_valid    = out_valid_q;
	assign mixed_sample = mixed_q;
	assign out_free     = !out_valid_q || !out_stall;
	assign out_load     = is_mix && (step_q == MS_OUT) && out_free;

	// Read side: line 0 is fetched in the last set-up step, each following line
	// during the write step of the line before it.
	assign rd_en   = (is_prep && step_q == PS_LPC) ||
	                 (is_line && step_q == LS_WRITE && line_q != LAST_LINE);
	assign rd_line = is_prep ? LINE_A : line_q + 2'd1;
	assign rd_tap  = tap_len(rd_line);
	always_comb begin
		if ({1'b0, wp_q} >= (PW + 1)'(rd_tap))
			rp_full = {1'b0, wp_q} - (PW + 1)'(rd_tap);
		else
			rp_full = {1'b0, wp_q} + DEPTH_EXT - (PW + 1)'(rd_tap);
	end
	assign rp             = rp_full[PW-1:0];
	assign rd_valid_entry = wrapped_q || (rp < wp_q);
	assign rd_addr        = line_base(rd_line) + MAW'(rp);

	// Never-written entries read as zero.
	assign x_in = rd_ok_q ? rd_data : '0;

	// Rounding and saturation of the registered product.
	assign p_rnd   = rnd16(prod_q);
	assign p_rnd_w = 30'(p_rnd);
	assign ap_cur  = (step_q == LS_AP0_OUT) ? ap0_q[line_q] : ap1_q[line_q];
	assign y_new   = sat20(p_rnd_w + 30'(ap_cur));
	assign apw_new = sat20(30'(xa_q) - p_rnd_w);
	assign lp_new  = sat20(30'(lp_q[line_q]) + p_rnd_w);
	assign wr_data = sat16(30'(dry_q) + p_rnd_w);
	assign mix_sum = acc_q + prod_q;
	assign out_new = sat16(30'(rnd16(mix_sum)));

	assign wr_en   = is_line && (step_q == LS_WRITE);
	assign wr_addr = line_base(line_q) + MAW'(wp_q);

	assign wet_abs    = wet_q[21] ? -wet_q : wet_q;
	assign dry_weight = UNITY_Q16 - {1'b0, mix_amt_q};
	assign wet_mag    = prod_q[41:22];

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_en = 1'b0;
		op_a   = '0;
		op_b   = '0;
		unique case (state_q)
			ST_PREP: begin
				unique case (step_q)
					PS_DECAY: begin
						mul_en = 1'b1;
						op_a   = 22'(decay_amt_q);
						op_b   = Q16_085;
					end
					PS_TONE: begin
						mul_en = 1'b1;
						op_a   = 22'(tone_amt_q);
						op_b   = Q16_060;
					end
					default: ;
				endcase
			end
			ST_LINE: begin
				unique case (step_q)
					LS_AP0_MUL_X: begin
						mul_en = 1'b1;
						op_a   = 22'(x_in);
						op_b   = AP_C0;
					end
					LS_AP0_MUL_Y: begin
						mul_en = 1'b1;
						op_a   = 22'(y_q);
						op_b   = AP_C0;
					end
					LS_AP0_ST, LS_AP1_MUL_Y: begin
						mul_en = 1'b1;
						op_a   = 22'(y_q);
						op_b   = AP_C1;
					end
					LS_AP1_ST: begin
						mul_en = 1'b1;
						op_a   = 22'(diff_q);
						op_b   = 22'(lpc_q);
					end
					LS_FB_MUL: begin
						mul_en = 1'b1;
						op_a   = 22'(lp_q[line_q]);
						op_b   = 22'(decay_q);
					end
					default: ;
				endcase
			end
			ST_MIX: begin
				unique case (step_q)
					MS_DIV: begin
						mul_en = 1'b1;
						op_a   = $signed(n_q);
						op_b   = DIV3_RECIP;
					end
					MS_WET: begin
						mul_en = 1'b1;
						op_a   = 22'(dry_q);
						op_b   = 22'(dry_weight);
					end
					MS_DRY: begin
						mul_en = 1'b1;
						op_a   = 22'(wet_mean_q);
						op_b   = 22'(mix_amt_q);
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	srv_line_mem #(
		.DEPTH (MEM_DEPTH)
	) u_line_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// Sequencer, configuration and filter state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			line_q      <= LINE_A;
			wp_q        <= '0;
			wrapped_q   <= 1'b0;
			decay_amt_q <= 16'h8000;
			tone_amt_q  <= 16'h8000;
			mix_amt_q   <= 16'h8000;
			out_valid_q <= 1'b0;
			for (int i = 0; i < LINE_COUNT; i++) begin
				ap0_q[i] <= '0;
				ap1_q[i] <= '0;
				lp_q[i]  <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_DECAY: decay_amt_q <= cfg_data;
					CFG_TONE:  tone_amt_q  <= cfg_data;
					CFG_MIX:   mix_amt_q   <= cfg_data;
					default:   ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_PREP;
						step_q  <= PS_DECAY;
					end
				end
				ST_PREP: begin
					if (step_q == PS_LPC) begin
						state_q <= ST_LINE;
						step_q  <= LS_AP0_MUL_X;
						line_q  <= LINE_A;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				ST_LINE: begin
					unique case (step_q)
						LS_AP0_ST:  ap0_q[line_q] <= apw_new;
						LS_AP1_ST:  ap1_q[line_q] <= apw_new;
						LS_LP_POST: lp_q[line_q]  <= lp_new;
						default:    ;
					endcase
					if (step_q == LS_WRITE) begin
						if (line_q == LAST_LINE) begin
							// all lines written: advance the shared write position
							state_q <= ST_MIX;
							step_q  <= MS_DIV;
							if (wp_q == POS_LAST) begin
								wp_q      <= '0;
								wrapped_q <= 1'b1;
							end else begin
								wp_q <= wp_q + PW'(1);
							end
						end else begin
							line_q <= line_q + 2'd1;
							step_q <= LS_AP0_MUL_X;
						end
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				ST_MIX: begin
					if (step_q == MS_OUT) begin
						if (out_free)
							state_q <= ST_IDLE;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			dry_q <= dry_sample;
			wet_q <= '0;
		end
		if (mul_en)
			prod_q <= op_a * op_b;
		if (rd_en)
			rd_ok_q <= rd_valid_entry;
		if (out_load)
			mixed_q <= out_new;

		if (is_prep && step_q == PS_TONE)
			decay_q <= p_rnd[15:0];
		if (is_prep && step_q == PS_LPC)
			lpc_q <= p_rnd[15:0] + LPC_BASE;

		if (is_line) begin
			unique case (step_q)
				LS_AP0_MUL_X: xa_q <= 20'(x_in);
				LS_AP0_OUT:   y_q  <= y_new;
				LS_AP0_ST:    xa_q <= y_q;
				LS_AP1_OUT:   y_q  <= y_new;
				LS_AP1_MUL_Y: diff_q <= 21'(y_q) - 21'(lp_q[line_q]);
				LS_FB_MUL:    wet_q  <= wet_q + 22'(lp_q[line_q]);
				LS_WRITE: begin
					// magnitude plus one for the mean, rounded to nearest
					n_q       <= wet_abs + 22'd1;
					wet_neg_q <= wet_q[21];
				end
				default: ;
			endcase
		end

		if (is_mix && step_q == MS_WET)
			wet_mean_q <= wet_neg_q ? -$signed({1'b0, wet_mag}) : $signed({1'b0, wet_mag});
		if (is_mix && step_q == MS_DRY)
			acc_q <= prod_q;
	end

	// Read and write of one step always fall in different lines.
	a_mem_no_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && wr_en) |-> (rd_addr != wr_addr))
		else $error("line memory read and write hit the same entry");

	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || !out_stall))
		else $error("output register overwritten while its item is pending");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (in_stall && state_q == ST_PREP))
		else $error("accepted item did not start processing");

	a_line_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		is_line |-> (step_q <= LS_WRITE && line_q <= LAST_LINE))
		else $error("line sequencer out of range");

	a_wp_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(wp_q != $past(wp_q)) |-> (state_q == ST_MIX && step_q == MS_DIV))
		else $error("write position moved outside the end of the line pass");

endmodule

FILE: design/srv_line_mem.sv
// Single-port-write, single-port-read sample memory holding the three delay lines.
`timescale 1ns / 1ps

module srv_line_mem #(
	parameter int DEPTH = 3072
) (
	input  logic                         clk,
	input  logic                         rd_en,
	input  logic [$clog2(DEPTH)-1:0]     rd_addr,
	output srv_pkg::sample_t             rd_data,
	input  logic                         wr_en,
	input  logic [$clog2(DEPTH)-1:0]     wr_addr,
	input  srv_pkg::sample_t             wr_data
);
	import srv_pkg::*;

	sample_t mem_q [DEPTH];
	sample_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		if (rd_en)
			rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule
